FILE: design/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared sizes, register map and codes for the lru key/value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int EFF_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W  = 32;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // register map, word index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    // request codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

endpackage

`default_nettype wire

FILE: design/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value store with least recently used replacement
// ----------------------------------------------------------------------------
//  port group   direction  beat content
//  s_*          in         action, lookup_key, store_value
//  m_*          out        hit, read_value (one beat per get, none per put)
//  p*           apb        capacity register at byte address 0
//
//  a put runs the scan, last and update states, a get also the result state, held by any output stall
//  the key memory read port is swept one slot per cycle across all 16 slots
//  one request at a time: s_ready is low from acceptance to completion
//  reset is synchronous: clears valid bits, ranks, count, capacity to 16
//  no clearing pass after reset, the result register parts the m_ side
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_action,
    input  wire logic signed [lkv_pkg::DATA_W-1:0] s_lookup_key,
    input  wire logic signed [lkv_pkg::DATA_W-1:0] s_store_value,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_hit,
    output logic signed [lkv_pkg::DATA_W-1:0]     m_read_value,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lkv_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [lkv_pkg::PDATA_W-1:0]      pwdata,
    output logic      [lkv_pkg::PDATA_W-1:0]      prdata,
    output logic                                  pready
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_LAST   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    typedef logic [lkv_pkg::IDX_W-1:0]  idx_t;
    typedef logic [lkv_pkg::CNT_W-1:0]  cnt_t;
    typedef logic [lkv_pkg::DATA_W-1:0] word_t;

    state_t state_reg, state_next;

    logic [lkv_pkg::ENTRIES-1:0] valid_reg, valid_next;
    idx_t rank_reg [lkv_pkg::ENTRIES];
    idx_t rank_next [lkv_pkg::ENTRIES];
    cnt_t count_reg, count_next;
    logic [lkv_pkg::CAP_W-1:0] cap_reg;

    idx_t scan_cnt_reg, scan_cnt_next;
    logic cmp_vld_reg, cmp_vld_next;
    idx_t cmp_idx_reg, cmp_idx_next;
    logic found_reg, found_next;
    idx_t found_idx_reg, found_idx_next;
    idx_t hit_rank_reg, hit_rank_next;
    logic free_found_reg, free_found_next;
    idx_t free_idx_reg, free_idx_next;

    logic  act_reg, act_next;
    word_t key_reg, key_next;
    word_t val_reg, val_next;

    logic  m_valid_reg, m_valid_next;
    logic  m_hit_reg, m_hit_next;
    word_t m_read_value_reg, m_read_value_next;

    logic  key_we, val_we;
    idx_t  val_waddr;
    word_t key_rdata, val_rdata;

    logic [lkv_pkg::EFF_W-1:0] cap_ext;
    cnt_t eff_cap, evict_limit;
    logic cfg_wr;

    // key store, swept by the scan counter
    lkv_ram #(
        .WIDTH(lkv_pkg::DATA_W),
        .DEPTH(lkv_pkg::ENTRIES)
    ) u_key_ram (
        .aclk (aclk),
        .we   (key_we),
        .waddr(free_idx_reg),
        .wdata(key_reg),
        .raddr(scan_cnt_reg),
        .rdata(key_rdata)
    );

    // value store, read at the matching slot
    lkv_ram #(
        .WIDTH(lkv_pkg::DATA_W),
        .DEPTH(lkv_pkg::ENTRIES)
    ) u_val_ram (
        .aclk (aclk),
        .we   (val_we),
        .waddr(val_waddr),
        .wdata(val_reg),
        .raddr(found_idx_reg),
        .rdata(val_rdata)
    );

    // effective capacity, clamped to 1..ENTRIES
    always_comb begin
        cap_ext = lkv_pkg::EFF_W'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = lkv_pkg::CNT_W'(1);
        end else if (cap_ext > lkv_pkg::EFF_W'(lkv_pkg::ENTRIES)) begin
            eff_cap = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
        end else begin
            eff_cap = lkv_pkg::CNT_W'(cap_reg);
        end
        evict_limit = eff_cap - lkv_pkg::CNT_W'(1);
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lkv_pkg::REG_CAPACITY)
                  ? {{(lkv_pkg::PDATA_W-lkv_pkg::CAP_W){1'b0}}, cap_reg}
                  : '0;

    always_comb begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        rank_next         = rank_reg;
        count_next        = count_reg;
        scan_cnt_next     = scan_cnt_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = scan_cnt_reg;
        found_next        = found_reg;
        found_idx_next    = found_idx_reg;
        hit_rank_next     = hit_rank_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        act_next          = act_reg;
        key_next          = key_reg;
        val_next          = val_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_hit_next        = m_hit_reg;
        m_read_value_next = m_read_value_reg;
        key_we            = 1'b0;
        val_we            = 1'b0;
        val_waddr         = free_idx_reg;

        // compare stage, one slot per cycle behind the key read
        if (cmp_vld_reg) begin
            if (!found_reg && valid_reg[cmp_idx_reg] && key_rdata == key_reg) begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
                hit_rank_next  = rank_reg[cmp_idx_reg];
            end
            if (!free_found_reg && (!valid_reg[cmp_idx_reg] ||
                    lkv_pkg::CNT_W'(rank_reg[cmp_idx_reg]) >= evict_limit)) begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next        = s_action;
                    key_next        = s_lookup_key;
                    val_next        = s_store_value;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                cmp_vld_next  = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == lkv_pkg::IDX_W'(lkv_pkg::ENTRIES - 1)) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (found_reg) begin
                    // move the hit slot to the front
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                        if (valid_reg[i] && rank_reg[i] < hit_rank_reg) begin
                            rank_next[i] = rank_reg[i] + 1'b1;
                        end
                    end
                    rank_next[found_idx_reg] = '0;
                    if (act_reg == lkv_pkg::ACT_PUT) begin
                        val_we    = 1'b1;
                        val_waddr = found_idx_reg;
                    end
                end else if (act_reg == lkv_pkg::ACT_PUT) begin
                    // evict down to capacity-1, age survivors, insert at front
                    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                        if (valid_reg[i]) begin
                            if (lkv_pkg::CNT_W'(rank_reg[i]) >= evict_limit) begin
                                valid_next[i] = 1'b0;
                                rank_next[i]  = '0;
                            end else begin
                                rank_next[i] = rank_reg[i] + 1'b1;
                            end
                        end
                    end
                    valid_next[free_idx_reg] = 1'b1;
                    rank_next[free_idx_reg]  = '0;
                    key_we = 1'b1;
                    val_we = 1'b1;
                    count_next = ((count_reg >= eff_cap) ? evict_limit : count_reg)
                               + lkv_pkg::CNT_W'(1);
                end
                state_next = (act_reg == lkv_pkg::ACT_PUT) ? S_IDLE : S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_hit_next        = found_reg;
                    m_read_value_next = found_reg ? val_rdata : '1;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
            count_reg      <= '0;
            cap_reg        <= lkv_pkg::CAP_RESET;
            cmp_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            rank_reg       <= rank_next;
            count_reg      <= count_next;
            cmp_vld_reg    <= cmp_vld_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr && paddr[2] == lkv_pkg::REG_CAPACITY) begin
                cap_reg <= pwdata[lkv_pkg::CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_cnt_reg     <= scan_cnt_next;
        cmp_idx_reg      <= cmp_idx_next;
        found_idx_reg    <= found_idx_next;
        hit_rank_reg     <= hit_rank_next;
        free_idx_reg     <= free_idx_next;
        act_reg          <= act_next;
        key_reg          <= key_next;
        val_reg          <= val_next;
        m_hit_reg        <= m_hit_next;
        m_read_value_reg <= m_read_value_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_read_value = m_read_value_reg;

    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg))
        else $error("occupancy count disagrees with valid bits");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lkv_pkg::CNT_W'(lkv_pkg::ENTRIES))
        else $error("occupancy count above slot count");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while scan in progress");

    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_reg) |-> (m_read_value_reg == '1))
        else $error("miss beat without all-ones value");

    a_insert_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPDATE && act_reg == lkv_pkg::ACT_PUT && !found_reg)
        |-> free_found_reg)
        else $error("insert without a free slot");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lru key/value cache: directed and random
// get/put traffic under several capacity settings, each get result checked
// against an in-bench lru predictor, with bursty input and stalled output
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 40;
    localparam int PHASE_ITEMS = 78;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic                      action;
        logic [lkv_pkg::DATA_W-1:0] key;
        logic [lkv_pkg::DATA_W-1:0] value;
    } cache_request_t;

    typedef struct packed {
        logic                      hit;
        logic [lkv_pkg::DATA_W-1:0] value;
    } lookup_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                              s_valid       = 1'b0;
    logic                              s_ready;
    logic                              s_action      = lkv_pkg::ACT_GET;
    logic signed [lkv_pkg::DATA_W-1:0] s_lookup_key  = '0;
    logic signed [lkv_pkg::DATA_W-1:0] s_store_value = '0;

    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_hit;
    logic signed [lkv_pkg::DATA_W-1:0] m_read_value;

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [lkv_pkg::PADDR_W-1:0] paddr   = '0;
    logic [lkv_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [lkv_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    lru_key_value_cache dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_lookup_key  (s_lookup_key),
        .s_store_value (s_store_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [lkv_pkg::DATA_W-1:0] cache_key   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] cache_val   [lkv_pkg::ENTRIES];
    bit                         cache_used  [lkv_pkg::ENTRIES] = '{default: 1'b0};
    int unsigned                cache_rank  [lkv_pkg::ENTRIES] = '{default: 0};
    int unsigned                cache_count = 0;
    logic [lkv_pkg::CAP_W-1:0]  capacity_reg = lkv_pkg::CAP_RESET;

    cache_request_t cache_requests[$];
    lookup_result_t lookup_expect[$];
    logic [lkv_pkg::DATA_W-1:0] key_pool[POOL_SIZE];
    int key_span = POOL_SIZE - 1;

    int mismatch_count = 0;
    int requests_sent  = 0;
    int gets_sent      = 0;
    int hits_predicted = 0;
    int evictions      = 0;
    int updates        = 0;
    int results_seen   = 0;
    int cap_writes     = 0;

    int burst_left  = 0;
    int gap_left    = 0;
    int ready_left  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    function automatic void make_recent(input int slot);
        int unsigned r;
        r = cache_rank[slot];
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (cache_used[i] && cache_rank[i] < r) cache_rank[i]++;
        end
        cache_rank[slot] = 0;
    endfunction

    function automatic void cache_access(input cache_request_t req);
        int slot;
        int free_slot;
        int unsigned eff_cap;
        bit dropped;
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (slot < 0 && cache_used[i] && cache_key[i] == req.key) slot = i;
        end
        if (req.action == lkv_pkg::ACT_GET) begin
            gets_sent++;
            if (slot >= 0) begin
                make_recent(slot);
                hits_predicted++;
                lookup_expect.push_back('{hit: 1'b1, value: cache_val[slot]});
            end else begin
                lookup_expect.push_back('{hit: 1'b0, value: '1});
            end
        end else if (slot >= 0) begin
            make_recent(slot);
            cache_val[slot] = req.value;
            updates++;
        end else begin
            eff_cap = (capacity_reg == 0) ? 1 :
                      (capacity_reg > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : capacity_reg;
            while (cache_count >= eff_cap && cache_count > 0) begin
                dropped = 1'b0;
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (!dropped && cache_used[i] && cache_rank[i] == cache_count - 1) begin
                        cache_used[i] = 1'b0;
                        cache_rank[i] = 0;
                        dropped = 1'b1;
                    end
                end
                cache_count--;
                evictions++;
            end
            for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                if (!cache_used[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else begin
                    cache_rank[i]++;
                end
            end
            cache_used[free_slot] = 1'b1;
            cache_key[free_slot]  = req.key;
            cache_val[free_slot]  = req.value;
            cache_rank[free_slot] = 0;
            cache_count++;
        end
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [lkv_pkg::DATA_W-1:0] want,
                                   input logic [lkv_pkg::DATA_W-1:0] got);
        $display("mismatch at %0t: %s want %h got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // sender: bursts of random length with random gaps between them
    always @(posedge aclk) begin : drive_requests
        logic taken;
        cache_request_t req;
        taken = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (taken) begin
                req = cache_requests.pop_front();
                cache_access(req);
                requests_sent++;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                end
            end
            if (s_valid && !taken) begin
                s_valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (cache_requests.size() > 0) begin
                s_valid       <= 1'b1;
                s_action      <= cache_requests[0].action;
                s_lookup_key  <= cache_requests[0].key;
                s_store_value <= cache_requests[0].value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: ready stretches alternating with stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            ready_left = $urandom_range(1, 40);
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin : check_results
        lookup_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (lookup_expect.size() == 0) begin
                report_mismatch("result beat with nothing expected", '0, m_read_value);
            end else begin
                want = lookup_expect.pop_front();
                if (m_hit !== want.hit)
                    report_mismatch("hit", lkv_pkg::DATA_W'(want.hit),
                                    lkv_pkg::DATA_W'(m_hit));
                if (m_read_value !== want.value)
                    report_mismatch("read_value", want.value, m_read_value);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {lkv_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= lkv_pkg::PDATA_W'(cap);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        capacity_reg = cap;
        cap_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cache_requests.size() != 0 || lookup_expect.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic void queue_request(input logic act,
                                          input logic [lkv_pkg::DATA_W-1:0] key,
                                          input logic [lkv_pkg::DATA_W-1:0] value);
        cache_requests.push_back('{action: act, key: key, value: value});
    endfunction

    function automatic logic [lkv_pkg::DATA_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return key_pool[$urandom_range(0, key_span)];
    endfunction

    function automatic logic [lkv_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 45)
                queue_request(lkv_pkg::ACT_PUT, pick_key(), pick_value());
            else
                queue_request(lkv_pkg::ACT_GET, pick_key(), $urandom);
        end
    endfunction

    initial begin : stimulus
        logic [lkv_pkg::CAP_W-1:0] cap_plan[8];
        cap_plan = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd2, 5'd12, 5'd16, 5'd17};
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'hffff_ffff;
        key_pool[3] = 32'h0000_0000;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, hit on all-ones value, update, eviction
        queue_request(lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkv_pkg::ACT_PUT, 32'h8000_0000, 32'h7fff_ffff);
        queue_request(lkv_pkg::ACT_PUT, 32'h7fff_ffff, 32'h8000_0000);
        queue_request(lkv_pkg::ACT_PUT, 32'hffff_ffff, 32'h0000_0000);
        queue_request(lkv_pkg::ACT_PUT, 32'h0000_0000, 32'hffff_ffff);
        queue_request(lkv_pkg::ACT_GET, 32'h8000_0000, 32'hffff_ffff);
        queue_request(lkv_pkg::ACT_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_request(lkv_pkg::ACT_GET, 32'hffff_ffff, 32'h0000_0000);
        queue_request(lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(lkv_pkg::ACT_PUT, 32'h7fff_ffff, 32'h1234_5678);
        queue_request(lkv_pkg::ACT_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_request(lkv_pkg::ACT_GET, 32'h0000_0001, 32'h0000_0000);
        for (int i = 0; i < 13; i++) queue_request(lkv_pkg::ACT_PUT, 32'd100 + i, $urandom);
        queue_request(lkv_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
        wait_drained();

        // capacity phases, the first lowers capacity below occupancy
        foreach (cap_plan[p]) begin
            write_capacity(cap_plan[p]);
            key_span = (cap_plan[p] > 19) ? POOL_SIZE - 1 : cap_plan[p] + 4;
            queue_random(PHASE_ITEMS);
            wait_drained();
        end

        $display("covered %0d requests (%0d gets, %0d predicted hits, %0d results checked)",
                 requests_sent, gets_sent, hits_predicted, results_seen);
        $display("%0d evictions, %0d in-place updates, %0d capacity writes, %0d mismatches",
                 evictions, updates, cap_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
